// File: hdl/button_debounce_key_report_macros.svh
// assertion macros of the debounce key report design
`ifndef BUTTON_DEBOUNCE_KEY_REPORT_MACROS_SVH
`define BUTTON_DEBOUNCE_KEY_REPORT_MACROS_SVH

// same-cycle implication, checked on clk, off during reset
`define BDK_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked on clk, off during reset
`define BDK_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/bdk_pkg.sv
// shared types, constants and helpers of the debounce key report block
package bdk_pkg;

	localparam int NUM_PINS   = 16;
	localparam int MAX_KEYS   = 6;
	localparam int KEY_SLOTS  = 6;
	localparam int PIN_W      = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 16;
	localparam int KEY_W      = 8;
	localparam int SLOT_CNT_W = 3;
	localparam int ADDR_W     = 5;
	localparam int CFG_DATA_W = 64;
	localparam int ITEM_W     = LEVEL_W + TIME_W + 2;
	localparam int RES_W      = 2 + KEY_SLOTS * KEY_W;
	localparam int IN_TDATA_W = ((ITEM_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((RES_W + 7) / 8) * 8;

	localparam logic [PIN_W-1:0]      LAST_PIN = PIN_W'(NUM_PINS - 1);
	localparam logic [LEVEL_W-1:0]    PIN_SPAN = LEVEL_W'((33'd1 << NUM_PINS) - 33'd1);
	localparam logic [SLOT_CNT_W-1:0] SLOT_MAX = SLOT_CNT_W'(MAX_KEYS);

	// reset values of the registers
	localparam logic [63:0] RST_KEY_MAP_LOW  = 64'd4;
	localparam logic [63:0] RST_KEY_MAP_HIGH = 64'd0;
	localparam logic [7:0]  RST_LOCKOUT_MS   = 8'd5;
	localparam logic [15:0] RST_PIN_ENABLE   = 16'd63487;

	typedef enum logic [1:0] {
		REG_KEY_MAP_LOW  = 2'd0,
		REG_KEY_MAP_HIGH = 2'd1,
		REG_LOCKOUT_MS   = 2'd2,
		REG_PIN_ENABLE   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [63:0] key_map_high;
		logic [63:0] key_map_low;
		logic [7:0]  lockout_ms;
		logic [15:0] pin_enable;
	} cfg_t;

	// raw_levels in the lowest bits
	typedef struct packed {
		logic               bus_suspended;
		logic               host_ready;
		logic [TIME_W-1:0]  now_ms;
		logic [LEVEL_W-1:0] raw_levels;
	} item_t;

	// send_report in the lowest bit
	typedef struct packed {
		logic                             wake_request;
		logic [KEY_SLOTS-1:0][KEY_W-1:0]  keys;
		logic                             send_report;
	} result_t;

	// keycode of one button from the two map registers
	function automatic logic [KEY_W-1:0] keycode_of(input logic [63:0] map_lo,
			input logic [63:0] map_hi, input logic [3:0] pin);
		logic [127:0] map;
		begin
			map = {map_hi, map_lo};
			return map[{pin, 3'b000} +: KEY_W];
		end
	endfunction

endpackage

// File: hdl/bdk_ram.sv
// generic single write port ram with registered read
module bdk_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// File: hdl/bdk_cfg.sv
// register file behind the apb configuration port
module bdk_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [bdk_pkg::ADDR_W-1:0]      paddr,
	input  logic [bdk_pkg::CFG_DATA_W-1:0]  pwdata,
	output logic [bdk_pkg::CFG_DATA_W-1:0]  prdata,
	output logic                            pready,
	output bdk_pkg::cfg_t                   cfg
);
	import bdk_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t reg_sel;
	logic     wr_en;

	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[4:3]);
	assign wr_en   = psel & penable & pwrite;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.key_map_low  <= RST_KEY_MAP_LOW;
			cfg_q.key_map_high <= RST_KEY_MAP_HIGH;
			cfg_q.lockout_ms   <= RST_LOCKOUT_MS;
			cfg_q.pin_enable   <= RST_PIN_ENABLE;
		end else if (wr_en) begin
			case (reg_sel)
				REG_KEY_MAP_LOW:  cfg_q.key_map_low  <= pwdata;
				REG_KEY_MAP_HIGH: cfg_q.key_map_high <= pwdata;
				REG_LOCKOUT_MS:   cfg_q.lockout_ms   <= pwdata[7:0];
				REG_PIN_ENABLE:   cfg_q.pin_enable   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		case (reg_sel)
			REG_KEY_MAP_LOW:  prdata = cfg_q.key_map_low;
			REG_KEY_MAP_HIGH: prdata = cfg_q.key_map_high;
			REG_LOCKOUT_MS:   prdata = {56'd0, cfg_q.lockout_ms};
			REG_PIN_ENABLE:   prdata = {48'd0, cfg_q.pin_enable};
			default:          prdata = '0;
		endcase
	end
endmodule

// File: hdl/bdk_walk.sv
// debounce walker: per-pin read-modify-write of the change time ram and slot fill
module bdk_walk (
	input  logic              clk,
	input  logic              arst_n,
	input  bdk_pkg::cfg_t     cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  bdk_pkg::item_t    in_item,
	output logic              res_valid,
	input  logic              res_ready,
	output bdk_pkg::result_t  res
);
	import bdk_pkg::*;

	`include "button_debounce_key_report_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_WALK = 4'b0010,
		ST_LAST = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t                          state_q;
	item_t                           buf_q;
	logic                            buf_valid_q;
	item_t                           item_q;
	logic                            equal_q;
	logic                            updated_q;
	logic [LEVEL_W-1:0]              stable_q;
	logic [NUM_PINS-1:0]             written_q;
	logic                            had_keys_q;
	logic [PIN_W-1:0]                idx_q;
	logic [PIN_W-1:0]                pin_s1;
	logic                            vld_s1;
	logic [SLOT_CNT_W-1:0]           cnt_q;
	logic [KEY_SLOTS-1:0][KEY_W-1:0] slots_q;

	logic [LEVEL_W-1:0] en;
	logic               start;
	logic               start_equal;
	logic [3:0]         pin4;
	logic [TIME_W-1:0]  ram_rdata;
	logic [TIME_W-1:0]  cur_time;
	logic [TIME_W-1:0]  elapsed;
	logic               differs;
	logic               toggle;
	logic               new_bit;
	logic               take;
	logic               wake;
	logic               send;
	logic               finish;

	// item acceptance and start of a walk
	assign en          = cfg.pin_enable & PIN_SPAN;
	assign in_ready    = !buf_valid_q;
	assign start       = (state_q == ST_IDLE) && buf_valid_q;
	assign start_equal = (buf_q.raw_levels & en) == (stable_q & en);

	// per-pin debounce decision on the registered ram read data
	assign pin4     = 4'(pin_s1);
	assign cur_time = written_q[pin_s1] ? ram_rdata : '0;
	assign elapsed  = item_q.now_ms - cur_time;
	assign differs  = en[pin4] & (stable_q[pin4] ^ item_q.raw_levels[pin4]) & !equal_q;
	assign toggle   = vld_s1 && differs && (elapsed > {24'd0, cfg.lockout_ms});
	assign new_bit  = stable_q[pin4] ^ toggle;
	assign take     = vld_s1 && new_bit && en[pin4] && (cnt_q < SLOT_MAX);

	// result of the finished walk
	assign wake      = item_q.bus_suspended & updated_q;
	assign send      = !wake & item_q.host_ready & (updated_q | had_keys_q);
	assign res_valid = (state_q == ST_DONE);
	assign finish    = res_valid && res_ready;

	always_comb begin
		res.send_report  = send;
		res.wake_request = wake;
		res.keys         = (send && updated_q) ? slots_q : '0;
	end

	// last-change time per pin
	bdk_ram #(
		.WIDTH(TIME_W),
		.DEPTH(NUM_PINS)
	) u_time_ram (
		.clk  (clk),
		.we   (toggle),
		.waddr(pin_s1),
		.wdata(item_q.now_ms),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			buf_valid_q <= 1'b0;
			vld_s1      <= 1'b0;
			stable_q    <= '0;
			written_q   <= '0;
			had_keys_q  <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			equal_q     <= 1'b0;
			updated_q   <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				buf_valid_q <= 1'b1;
			end else if (start) begin
				buf_valid_q <= 1'b0;
			end
			vld_s1 <= (state_q == ST_WALK);
			if (toggle) begin
				stable_q[pin4]    <= ~stable_q[pin4];
				written_q[pin_s1] <= 1'b1;
			end
			if (take) begin
				cnt_q <= cnt_q + SLOT_CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q   <= ST_WALK;
						equal_q   <= start_equal;
						updated_q <= start_equal ? |(stable_q & en) : 1'b1;
						idx_q     <= '0;
						cnt_q     <= '0;
					end
				end
				ST_WALK: begin
					idx_q <= idx_q + PIN_W'(1);
					if (idx_q == LAST_PIN) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (finish) begin
						state_q <= ST_IDLE;
						if (!wake && item_q.host_ready) begin
							had_keys_q <= updated_q;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pin_s1 <= idx_q;
		if (in_valid && in_ready) begin
			buf_q <= in_item;
		end
		if (start) begin
			item_q  <= buf_q;
			slots_q <= '0;
		end else if (take) begin
			slots_q[cnt_q] <= keycode_of(cfg.key_map_low, cfg.key_map_high, pin4);
		end
	end

	`BDK_ASSERT_IMP(a_write_in_walk, toggle, (state_q == ST_WALK || state_q == ST_LAST), "time ram written outside a walk")
	`BDK_ASSERT_IMP(a_slot_bound, state_q != ST_IDLE, cnt_q <= SLOT_MAX, "slot count past the limit")
	`BDK_ASSERT_NXT(a_last_to_done, state_q == ST_LAST, state_q == ST_DONE, "walk did not finish")
	`BDK_ASSERT_NXT(a_buf_taken, start, !buf_valid_q && state_q == ST_WALK, "buffered item not taken")
endmodule

// File: hdl/button_debounce_key_report.sv
// Debounced button panel that builds six-key keyboard reports.
// Input channel s_axis: one transfer is one poll (raw levels, time, host flags).
// Output channel m_axis: exactly one transfer per poll (report, keys, wakeup).
// Configuration through the apb port: key maps, lockout and pin enables at
// byte addresses 0, 8, 16 and 24; write only while no poll is in flight.
// Each poll walks all pins in order through the change time ram: one read
// per cycle, the write back in the cycle after the read, in the steps start,
// 16 reads, final pin and result; the next poll starts its walk only once
// the result of the last one has been taken. An input transfer reaches
// output valid through the input buffer, the walk and the output register.
// A one-item input buffer takes the next poll while a walk runs, and an
// output register holds the result, so a stalled receiver only blocks the
// next walk once the output register and the walker both hold a result.
// Reset clears debounced levels, had-keys flag, change times (through
// per-pin valid bits) and loads the register reset values.
module button_debounce_key_report (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// raw_levels, now_ms, host_ready, bus_suspended, zero fill
	input  logic [bdk_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// send_report, key_first .. key_sixth, wake_request, zero fill
	output logic [bdk_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bdk_pkg::ADDR_W-1:0]          paddr,
	input  logic [bdk_pkg::CFG_DATA_W-1:0]      pwdata,
	output logic [bdk_pkg::CFG_DATA_W-1:0]      prdata,
	output logic                                pready
);
	import bdk_pkg::*;

	cfg_t    cfg;
	item_t   in_item;
	result_t res;
	result_t out_q;
	logic    out_valid_q;
	logic    res_valid;
	logic    res_ready;

	assign in_item = item_t'(s_axis_tdata[ITEM_W-1:0]);

	bdk_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	bdk_walk u_walk (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_item  (in_item),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res      (res)
	);

	// output register
	assign res_ready     = !out_valid_q || m_axis_tready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(OUT_TDATA_W - RES_W)'(0), out_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end
endmodule

// File: dv/button_debounce_key_report_test.sv
// testbench of the debounced button key report block: directed table, random polls, checker
`timescale 1ns / 100ps

module button_debounce_key_report_test;
	import bdk_pkg::*;

	// one row of the directed table: a register write or a poll
	typedef struct packed {
		bit          is_cfg;
		reg_idx_t    reg_sel;
		logic [63:0] value;
		item_t       poll;
		bit          has_exp;
		result_t     exp_res;
	} step_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	// raw_levels, now_ms, host_ready, bus_suspended, zero fill
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	// send_report, key_first .. key_sixth, wake_request, zero fill
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   psel = 1'b0;
	logic                   penable = 1'b0;
	logic                   pwrite = 1'b0;
	logic [ADDR_W-1:0]      paddr = '0;
	logic [CFG_DATA_W-1:0]  pwdata = '0;
	logic [CFG_DATA_W-1:0]  prdata;
	logic                   pready;

	// predictor copy of the registers and of the debounce state
	logic [63:0] map_lo_m = RST_KEY_MAP_LOW;
	logic [63:0] map_hi_m = RST_KEY_MAP_HIGH;
	logic [7:0]  lockout_m = RST_LOCKOUT_MS;
	logic [15:0] pin_en_m = RST_PIN_ENABLE;
	logic [15:0] stable_m = '0;
	logic [31:0] chg_time_m [16];
	bit          had_keys_m = 1'b0;

	result_t report_q [$];
	int      mismatches = 0;
	int      burst_left = 0;
	bit      rx_on = 1'b0;
	int      rx_run = 0;
	result_t got, want;

	button_debounce_key_report dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < 16; i++) chg_time_m[i] = '0;
	end

	// debounce one poll and build the report it causes
	function automatic result_t debounce_poll(input item_t it);
		logic [15:0]  en;
		logic [15:0]  raw;
		logic [31:0]  elapsed;
		logic [127:0] map;
		int           n;
		bit           updated;
		result_t      r;
		en = PIN_SPAN & pin_en_m;
		raw = it.raw_levels & en;
		map = {map_hi_m, map_lo_m};
		r = '0;
		if (raw == (stable_m & en)) begin
			updated = (stable_m & en) != '0;
		end else begin
			for (int i = 0; i < NUM_PINS; i++) begin
				elapsed = it.now_ms - chg_time_m[i];
				if (en[i] && (stable_m[i] != raw[i]) && elapsed > {24'd0, lockout_m}) begin
					stable_m[i] = ~stable_m[i];
					chg_time_m[i] = it.now_ms;
				end
			end
			updated = 1'b1;
		end
		if (it.bus_suspended && updated) begin
			r.wake_request = 1'b1;
		end else if (it.host_ready) begin
			if (updated) begin
				n = 0;
				for (int i = 0; i < NUM_PINS; i++) begin
					if (stable_m[i] && en[i] && n < MAX_KEYS) begin
						r.keys[n] = map[i*8 +: 8];
						n++;
					end
				end
				r.send_report = 1'b1;
				had_keys_m = 1'b1;
			end else begin
				r.send_report = had_keys_m;
				had_keys_m = 1'b0;
			end
		end
		return r;
	endfunction

	function automatic step_t poll_row(input logic [15:0] raw, input logic [31:0] t,
			input bit rdy, input bit susp);
		step_t s;
		s = '0;
		s.poll.raw_levels = raw;
		s.poll.now_ms = t;
		s.poll.host_ready = rdy;
		s.poll.bus_suspended = susp;
		return s;
	endfunction

	function automatic step_t cfg_row(input reg_idx_t idx, input logic [63:0] v);
		step_t s;
		s = '0;
		s.is_cfg = 1'b1;
		s.reg_sel = idx;
		s.value = v;
		return s;
	endfunction

	// poll row with the report typed in: send flag, first slot, wakeup
	function automatic step_t checked(input step_t s, input bit send,
			input logic [7:0] first, input bit wake);
		s.has_exp = 1'b1;
		s.exp_res = '0;
		s.exp_res.send_report = send;
		s.exp_res.keys[0] = first;
		s.exp_res.wake_request = wake;
		return s;
	endfunction

	// apb write: setup then access, register taken when pready is high
	task automatic write_reg(input reg_idx_t idx, input logic [63:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_KEY_MAP_LOW:  map_lo_m = v;
			REG_KEY_MAP_HIGH: map_hi_m = v;
			REG_LOCKOUT_MS:   lockout_m = v[7:0];
			REG_PIN_ENABLE:   pin_en_m = v[15:0];
			default: ;
		endcase
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	// one input transfer, sent in bursts with idle gaps between them
	task automatic send_poll(input item_t it, input bit typed, input result_t typed_res);
		int      gap;
		result_t predicted;
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 24);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 30);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= IN_TDATA_W'(it);
		do @(posedge clk); while (!s_axis_tready);
		predicted = debounce_poll(it);
		report_q.push_back(typed ? typed_res : predicted);
		burst_left--;
		@(negedge clk);
	endtask

	// stop sending and wait until every report has come back
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (report_q.size() != 0) @(posedge clk);
		repeat (3) @(negedge clk);
	endtask

	// receiver: alternating runs of ready and stall
	always @(negedge clk) begin
		if (rx_run == 0) begin
			rx_on = ~rx_on;
			rx_run = rx_on ? $urandom_range(1, 40) : $urandom_range(1, 30);
			m_axis_tready <= rx_on;
		end else begin
			rx_run--;
		end
	end

	// compare each output transfer with the oldest expected report
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = result_t'(m_axis_tdata[RES_W-1:0]);
			if (report_q.size() == 0) begin
				$display("%0t: unexpected report transfer, expected none, got %h", $time, got);
				mismatches++;
			end else begin
				want = report_q.pop_front();
				if (got.send_report !== want.send_report) begin
					$display("%0t: send_report expected %0d got %0d", $time,
						want.send_report, got.send_report);
					mismatches++;
				end
				for (int k = 0; k < KEY_SLOTS; k++) begin
					if (got.keys[k] !== want.keys[k]) begin
						$display("%0t: key slot %0d expected %h got %h", $time, k,
							want.keys[k], got.keys[k]);
						mismatches++;
					end
				end
				if (got.wake_request !== want.wake_request) begin
					$display("%0t: wake_request expected %0d got %0d", $time,
						want.wake_request, got.wake_request);
					mismatches++;
				end
			end
		end
	end

	initial begin : stimulus
		step_t       plan [$];
		item_t       it;
		logic [15:0] target;
		logic [31:0] t;
		logic [63:0] maps [2];
		logic [7:0]  lock;
		logic [15:0] en;
		// reset defaults first: only button 0 maps to a keycode, pin 11 off
		plan = '{
			checked(poll_row(16'h0000, 32'd0, 1, 0), 0, 8'h00, 0),
			// press inside the lockout: updated but still empty
			checked(poll_row(16'h0001, 32'd3, 1, 0), 1, 8'h00, 0),
			// elapsed equal to lockout is still locked
			checked(poll_row(16'h0001, 32'd5, 1, 0), 1, 8'h00, 0),
			checked(poll_row(16'h0001, 32'd6, 1, 0), 1, 8'h04, 0),
			// held key while suspended asks for wakeup
			checked(poll_row(16'h0001, 32'd7, 0, 1), 0, 8'h00, 1),
			checked(poll_row(16'h0001, 32'd8, 0, 0), 0, 8'h00, 0),
			checked(poll_row(16'h0001, 32'd9, 1, 0), 1, 8'h04, 0),
			checked(poll_row(16'h0000, 32'd12, 1, 0), 1, 8'h00, 0),
			// suspended with nothing updated: release report instead of wakeup
			checked(poll_row(16'h0000, 32'd13, 1, 1), 1, 8'h00, 0),
			checked(poll_row(16'h0000, 32'd14, 1, 0), 0, 8'h00, 0),
			// disabled pin ignored
			checked(poll_row(16'h0800, 32'd15, 1, 0), 0, 8'h00, 0),
			cfg_row(REG_LOCKOUT_MS, 64'd0),
			cfg_row(REG_PIN_ENABLE, 64'hFFFF),
			cfg_row(REG_KEY_MAP_LOW, 64'h0807_0605_0403_0201),
			cfg_row(REG_KEY_MAP_HIGH, 64'h100F_0E0D_0C0B_0A09),
			// all pressed: only six slots
			poll_row(16'hFFFF, 32'd16, 1, 0),
			poll_row(16'h0000, 32'd16, 1, 0),
			poll_row(16'h0000, 32'hFFFF_FFFF, 1, 0),
			// time wraps around zero
			poll_row(16'hAAAA, 32'd0, 1, 0),
			cfg_row(REG_LOCKOUT_MS, 64'd255),
			cfg_row(REG_PIN_ENABLE, 64'd0),
			poll_row(16'hFFFF, 32'h8000_0000, 1, 0),
			cfg_row(REG_KEY_MAP_LOW, 64'd0),
			cfg_row(REG_KEY_MAP_HIGH, 64'hFFFF_FFFF_FFFF_FFFF),
			cfg_row(REG_PIN_ENABLE, 64'hFFFF),
			// zero keycodes, lockout boundary at 255
			poll_row(16'h5555, 32'd255, 1, 0),
			poll_row(16'hFFFF, 32'd256, 1, 0),
			poll_row(16'hFF00, 32'd600, 1, 0)
		};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table
		foreach (plan[k]) begin
			if (plan[k].is_cfg) begin
				settle();
				write_reg(plan[k].reg_sel, plan[k].value);
			end else begin
				send_poll(plan[k].poll, plan[k].has_exp, plan[k].exp_res);
			end
		end

		// random phases, each with its own register setting
		t = 32'd1000;
		target = '0;
		for (int ph = 0; ph < 11; ph++) begin
			settle();
			for (int m = 0; m < 2; m++) begin
				case ($urandom_range(0, 3))
					0: maps[m] = '0;
					1: maps[m] = '1;
					default: maps[m] = {$urandom, $urandom};
				endcase
			end
			case ($urandom_range(0, 3))
				0: lock = 8'd0;
				1: lock = 8'd255;
				default: lock = 8'($urandom_range(1, 12));
			endcase
			case ($urandom_range(0, 7))
				0: en = '0;
				1: en = RST_PIN_ENABLE;
				2, 3: en = '1;
				default: en = 16'($urandom);
			endcase
			write_reg(REG_KEY_MAP_LOW, maps[0]);
			write_reg(REG_KEY_MAP_HIGH, maps[1]);
			write_reg(REG_LOCKOUT_MS, {56'd0, lock});
			write_reg(REG_PIN_ENABLE, {48'd0, en});
			for (int n = 0; n < 50; n++) begin
				// held pattern with bounce, now and then a new pattern or noise
				if ($urandom_range(0, 5) == 0) begin
					case ($urandom_range(0, 3))
						0: target = '0;
						1: target = (16'd1 << $urandom_range(0, 15)) |
							(16'd1 << $urandom_range(0, 15));
						2: target = 16'($urandom);
						default: target = '1;
					endcase
				end
				it.raw_levels = target;
				if ($urandom_range(0, 3) == 0)
					it.raw_levels ^= 16'd1 << $urandom_range(0, 15);
				if ($urandom_range(0, 19) == 0)
					it.raw_levels = 16'($urandom);
				case ($urandom_range(0, 15))
					0: t = $urandom;
					1: t = 32'hFFFF_FFFF - $urandom_range(0, 600);
					default: t = t + $urandom_range(0, 2 * lock + 2);
				endcase
				it.now_ms = t;
				it.host_ready = $urandom_range(0, 7) != 0;
				it.bus_suspended = $urandom_range(0, 9) == 0;
				send_poll(it, 1'b0, '0);
			end
		end

		settle();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("button_debounce_key_report_test: PASS");
		else
			$display("button_debounce_key_report_test: FAIL");
		$finish;
	end

	// run limit
	initial begin
		#2_000_000;
		$display("button_debounce_key_report_test: FAIL");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hdl
hdl/bdk_pkg.sv
hdl/bdk_ram.sv
hdl/bdk_cfg.sv
hdl/bdk_walk.sv
hdl/button_debounce_key_report.sv
dv/button_debounce_key_report_test.sv
